// ===== rtl/hwo_pkg.sv =====
// ---------------------------------------------------------------------------
// hwo_pkg: shared types and constants of the Hermite wavetable oscillator.
// Holds command codes, register indexes and default parameter values.
// ---------------------------------------------------------------------------
package hwo_pkg;

  localparam int TableDepthDef  = 4096;
  localparam int SampleWidthDef = 24;

  localparam int CmdW   = 2;
  localparam int FreqW  = 32;
  localparam int TidxW  = 12;
  localparam int PhaseW = 32;
  localparam int CoefW  = 24;
  localparam int ScaleW = 40;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 40;

  typedef enum logic [CmdW-1:0] {
    CMD_SAMPLE = 2'd0,
    CMD_WRITE  = 2'd1,
    CMD_PHASE  = 2'd2,
    CMD_NONE   = 2'd3
  } cmd_t;

  typedef enum logic [CfgIdxW-1:0] {
    REG_OVS   = 3'd0,
    REG_TLOG  = 3'd1,
    REG_SCALE = 3'd2,
    REG_B0    = 3'd3,
    REG_B1    = 3'd4,
    REG_B2    = 3'd5,
    REG_A1    = 3'd6,
    REG_A2    = 3'd7
  } reg_idx_t;

  // Register values handed from the configuration file to the datapath.
  typedef struct packed {
    logic [4:0]              ovs;
    logic [3:0]              tlog;
    logic [ScaleW-1:0]       scale;
    logic signed [CoefW-1:0] b0;
    logic signed [CoefW-1:0] b1;
    logic signed [CoefW-1:0] b2;
    logic signed [CoefW-1:0] a1;
    logic signed [CoefW-1:0] a2;
  } cfg_t;

endpackage

// ===== rtl/hwo_if.sv =====
// ---------------------------------------------------------------------------
// hwo_in_if / hwo_out_if: valid-ready channels of the oscillator.
// One word moves at a clock edge where valid and ready are both high.
// ---------------------------------------------------------------------------
interface hwo_in_if;
  logic                valid;
  logic                ready;
  logic [1:0]          command;
  logic signed [31:0]  frequency;
  logic [11:0]         table_index;
  logic signed [23:0]  table_value;
  logic [31:0]         phase_value;
  modport source (output valid, command, frequency, table_index, table_value,
                  phase_value, input ready);
  modport sink (input valid, command, frequency, table_index, table_value,
                phase_value, output ready);
endinterface

interface hwo_out_if #(parameter int SW = 24);
  logic                 valid;
  logic                 ready;
  logic signed [SW-1:0] sample_out;
  modport source (output valid, sample_out, input ready);
  modport sink (input valid, sample_out, output ready);
endinterface

// ===== rtl/hwo_cfg.sv =====
// ---------------------------------------------------------------------------
// hwo_cfg: configuration register file.
// Decodes the write port and clamps nothing; clamping is done at use.
// ---------------------------------------------------------------------------
module hwo_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [hwo_pkg::CfgIdxW-1:0]   wr_idx,
  input  logic [hwo_pkg::CfgDataW-1:0]  wr_data,
  output hwo_pkg::cfg_t                 cfg
);
  import hwo_pkg::*;

  cfg_t cfg_r;

  // Register writes; reset loads the power-up values.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ovs   <= 5'd1;
      cfg_r.tlog  <= 4'd9;
      cfg_r.scale <= '0;
      cfg_r.b0    <= 24'sd4194304;
      cfg_r.b1    <= '0;
      cfg_r.b2    <= '0;
      cfg_r.a1    <= '0;
      cfg_r.a2    <= '0;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_idx))
        REG_OVS:   cfg_r.ovs   <= wr_data[4:0];
        REG_TLOG:  cfg_r.tlog  <= wr_data[3:0];
        REG_SCALE: cfg_r.scale <= wr_data[ScaleW-1:0];
        REG_B0:    cfg_r.b0    <= wr_data[CoefW-1:0];
        REG_B1:    cfg_r.b1    <= wr_data[CoefW-1:0];
        REG_B2:    cfg_r.b2    <= wr_data[CoefW-1:0];
        REG_A1:    cfg_r.a1    <= wr_data[CoefW-1:0];
        REG_A2:    cfg_r.a2    <= wr_data[CoefW-1:0];
        default:   ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/hwo_mac.sv =====
// ---------------------------------------------------------------------------
// hwo_mac: shared signed multiplier with a registered product.
// Every product of two signals in the oscillator goes through this one unit.
// ---------------------------------------------------------------------------
module hwo_mac (
  input  logic               clk,
  input  logic signed [32:0] op_a,
  input  logic signed [32:0] op_b,
  output logic signed [65:0] prod
);
  logic signed [65:0] prod_r;

  // One product a cycle, registered before use.
  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

// ===== rtl/hermite_wavetable_oscillator.sv =====
// ---------------------------------------------------------------------------
// hermite_wavetable_oscillator: wavetable oscillator with 4-point Hermite
// interpolation and an oversampled biquad filter.
// ---------------------------------------------------------------------------
// Usage: words enter on the in_ channel. A sample command runs
// oversample_factor passes and gives one word on the out_ channel; a table
// write or phase load gives none. Registers are to be written through cfg_
// only while the block is idle; the block itself does not enforce this.
// A table write or phase load is taken while idle, and the input is ready
// again in the next cycle. A sample command first forms the step product,
// then runs each pass as four table reads, three Horner products and five
// filter products, and ends in the output register. This order is set by
// the single shared multiplier, which serves the step, three Horner products
// and five filter taps, and by the one read port of the table.
// The input is not ready while a command is at work or while a result
// waits in the output register; a stalled receiver holds the result and
// the block until it is taken.
// Reset clears the phase and filter history and loads power-up register
// values; the table is not cleared and must be written before it is read.
// ---------------------------------------------------------------------------
module hermite_wavetable_oscillator #(
  parameter int TABLE_DEPTH  = hwo_pkg::TableDepthDef,
  parameter int SAMPLE_WIDTH = hwo_pkg::SampleWidthDef
) (
  input  logic                          clk,
  input  logic                          rst_n,
  hwo_in_if.sink                        in_ch,
  hwo_out_if.source                     out_ch,
  input  logic                          cfg_wr_en,
  input  logic [hwo_pkg::CfgIdxW-1:0]   cfg_idx,
  input  logic [hwo_pkg::CfgDataW-1:0]  cfg_data
);
  import hwo_pkg::*;

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int SW = SAMPLE_WIDTH;
  localparam logic signed [65:0] SMAX = 66'sd1 <<< (SW - 1);
  localparam logic signed [65:0] SMAXV = SMAX - 66'sd1;
  localparam logic signed [65:0] SMINV = -SMAX;

  typedef enum logic [14:0] {
    S_IDLE  = 15'b000000000000001,
    S_STEP  = 15'b000000000000010,
    S_STEPW = 15'b000000000000100,
    S_RD    = 15'b000000000001000,
    S_H3    = 15'b000000000010000,
    S_H2    = 15'b000000000100000,
    S_H1    = 15'b000000001000000,
    S_HX    = 15'b000000010000000,
    S_F0    = 15'b000000100000000,
    S_F1    = 15'b000001000000000,
    S_F2    = 15'b000010000000000,
    S_F3    = 15'b000100000000000,
    S_F4    = 15'b001000000000000,
    S_FE    = 15'b010000000000000,
    S_OUT   = 15'b100000000000000
  } state_t;

  cfg_t cfg;
  hwo_cfg u_cfg (.clk, .rst_n, .wr_en(cfg_wr_en), .wr_idx(cfg_idx),
                 .wr_data(cfg_data), .cfg);

  logic signed [32:0] op_a, op_b;
  logic signed [65:0] prod;
  hwo_mac u_mac (.clk, .op_a, .op_b, .prod);

  // Table memory: one write port, one registered read port.
  logic [SW-1:0] mem [TABLE_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr, mem_raddr;
  logic [SW-1:0] mem_wdata, mem_rdata_r;
  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    mem_rdata_r <= mem[mem_raddr];
  end

  state_t state_r, state_nxt;
  logic [1:0]  rcnt_r;          // table read counter within a pass
  logic [2:0]  rdone_r;         // words captured so far
  logic [4:0]  pass_r;
  logic [31:0] phase_r, step_r;
  logic signed [FreqW-1:0] freq_r;
  logic signed [SW-1:0] wa_r, wb_r, wc_r, wd_r;
  logic [23:0] frac_r;
  logic [AW-1:0] idx_r;
  logic signed [65:0] s_r, acc_r;
  logic signed [SW-1:0] xi_r, x1_r, x2_r, y1_r, y2_r;
  logic out_valid_r;
  logic signed [SW-1:0] out_data_r;

  // Clamped register views.
  logic [4:0] ovs_c;
  logic [3:0] lg_c;
  always_comb begin
    ovs_c = (cfg.ovs == 5'd0) ? 5'd1 : ((cfg.ovs > 5'd16) ? 5'd16 : cfg.ovs);
    lg_c  = (cfg.tlog < 4'd2) ? 4'd2 : ((cfg.tlog > 4'd12) ? 4'd12 : cfg.tlog);
  end

  // Index and fraction of the current phase.
  logic [31:0] idx_full, frac_full;
  logic [AW-1:0] idx_mask;
  always_comb begin
    idx_full  = phase_r >> (6'd32 - {2'b0, lg_c});
    frac_full = (phase_r << lg_c) >> 8;
    idx_mask  = AW'((32'd1 << lg_c) - 32'd1);
  end

  // Hermite coefficients, doubled and exact.
  logic signed [SW+4:0] h1, h2, h3;
  always_comb begin
    h1 = (SW+5)'(wc_r) - (SW+5)'(wa_r);
    h2 = 2 * (SW+5)'(wa_r) - 5 * (SW+5)'(wb_r) + 4 * (SW+5)'(wc_r)
       - (SW+5)'(wd_r);
    h3 = (SW+5)'(wd_r) - (SW+5)'(wa_r) + 3 * ((SW+5)'(wb_r) - (SW+5)'(wc_r));
  end

  function automatic logic signed [65:0] sat66(input logic signed [65:0] v);
    if (v > SMAXV) return SMAXV;
    if (v < SMINV) return SMINV;
    return v;
  endfunction

  // Running Horner sum and interpolated value, fed straight into the next
  // product so that the multiplier never sees a stale operand.
  logic signed [65:0] horner_sum;
  logic signed [SW-1:0] xi_c;
  always_comb begin
    horner_sum = (prod >>> 24) + ((state_r == S_H1) ? 66'(h1) : 66'(h2));
    xi_c       = SW'(sat66((s_r + 66'(wb_r) * 2) >>> 1));
  end

  // Operand selection for the shared multiplier.
  logic signed [32:0] frac_s;
  always_comb begin
    frac_s = $signed({9'd0, frac_r});
    op_a = '0;
    op_b = '0;
    unique case (state_r)
      S_STEP: begin
        op_a = 33'(freq_r);
        op_b = $signed({1'b0, cfg.scale[31:0]});
      end
      S_STEPW: begin
        op_a = 33'(freq_r);
        op_b = $signed({25'd0, cfg.scale[ScaleW-1:32]});
      end
      S_H3: begin op_a = 33'(h3); op_b = frac_s; end
      S_H2, S_H1: begin op_a = 33'(horner_sum); op_b = frac_s; end
      S_F0: begin op_a = 33'(cfg.b0); op_b = 33'(xi_c); end
      S_F1: begin op_a = 33'(cfg.b1); op_b = 33'(x1_r); end
      S_F2: begin op_a = 33'(cfg.b2); op_b = 33'(x2_r); end
      S_F3: begin op_a = 33'(cfg.a1); op_b = 33'(y1_r); end
      S_F4: begin op_a = 33'(cfg.a2); op_b = 33'(y2_r); end
      default: ;
    endcase
  end

  // Memory port control.
  always_comb begin
    mem_we    = (state_r == S_IDLE) && in_ch.valid && in_ch.ready
              && (cmd_t'(in_ch.command) == CMD_WRITE);
    mem_waddr = AW'(in_ch.table_index);
    mem_wdata = in_ch.table_value[SW-1:0];
    mem_raddr = (idx_r + AW'(rcnt_r)) & idx_mask;
  end

  assign in_ch.ready       = (state_r == S_IDLE) && !out_valid_r;
  assign out_ch.valid      = out_valid_r;
  assign out_ch.sample_out = out_data_r;

  // Sequencer.
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:  if (in_ch.valid && in_ch.ready
                   && cmd_t'(in_ch.command) == CMD_SAMPLE) state_nxt = S_STEP;
      S_STEP:  state_nxt = S_STEPW;
      S_STEPW: state_nxt = S_RD;
      S_RD:    if (rdone_r == 3'd4) state_nxt = S_H3;
      S_H3:    state_nxt = S_H2;
      S_H2:    state_nxt = S_H1;
      S_H1:    state_nxt = S_HX;
      S_HX:    state_nxt = S_F0;
      S_F0:    state_nxt = S_F1;
      S_F1:    state_nxt = S_F2;
      S_F2:    state_nxt = S_F3;
      S_F3:    state_nxt = S_F4;
      S_F4:    state_nxt = S_FE;
      S_FE:    state_nxt = (pass_r == ovs_c - 5'd1) ? S_OUT : S_RD;
      S_OUT:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      phase_r     <= '0;
      x1_r <= '0; x2_r <= '0; y1_r <= '0; y2_r <= '0;
      rcnt_r <= '0; rdone_r <= '0; pass_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (out_valid_r && out_ch.ready) out_valid_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          pass_r <= '0;
          if (in_ch.valid && in_ch.ready) begin
            freq_r <= in_ch.frequency;
            if (cmd_t'(in_ch.command) == CMD_PHASE) phase_r <= in_ch.phase_value;
          end
        end
        S_STEP: ;
        S_STEPW: begin
          // Low product arrives now.
          step_r <= 32'(prod >>> 32);
          idx_r  <= AW'(idx_full);
          frac_r <= frac_full[23:0];
          rcnt_r <= '0; rdone_r <= '0;
        end
        S_RD: begin
          // Step = (f*scale)>>32: low part plus high part shifted up.
          if (rdone_r == 3'd0 && rcnt_r == 2'd0 && pass_r == 5'd0)
            step_r <= step_r + 32'(prod);
          if (rcnt_r != 2'd3 || rdone_r == 3'd0) rcnt_r <= rcnt_r + 2'd1;
          if (rcnt_r != 2'd0 || rdone_r != 3'd0) begin
            rdone_r <= rdone_r + 3'd1;
            unique case (rdone_r)
              3'd0: wa_r <= mem_rdata_r;
              3'd1: wb_r <= mem_rdata_r;
              3'd2: wc_r <= mem_rdata_r;
              3'd3: wd_r <= mem_rdata_r;
              default: ;
            endcase
          end
        end
        S_H3: phase_r <= phase_r + step_r;
        S_H2, S_H1: s_r <= horner_sum;
        S_HX: s_r <= prod >>> 24;
        S_F0: xi_r <= xi_c;
        S_F1: acc_r <= prod;
        S_F2: acc_r <= acc_r + prod;
        S_F3: acc_r <= acc_r + prod;
        S_F4: acc_r <= acc_r - prod;
        S_FE: begin
          y2_r <= y1_r;
          y1_r <= SW'(sat66((acc_r - prod + (66'sd1 <<< 21)) >>> 22));
          x2_r <= x1_r;
          x1_r <= xi_r;
          pass_r <= pass_r + 5'd1;
          idx_r  <= AW'(idx_full);
          frac_r <= frac_full[23:0];
          rcnt_r <= '0; rdone_r <= '0;
        end
        S_OUT: begin
          out_valid_r <= 1'b1;
          out_data_r  <= y1_r;
        end
        default: ;
      endcase
    end
  end

endmodule

// ===== rtl/hwo_checker.sv =====
// ---------------------------------------------------------------------------
// hwo_checker: port-level checks of the oscillator.
// Watches the channels only and is bound to the top level.
// ---------------------------------------------------------------------------
module hwo_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_command,
  input logic        out_valid,
  input logic        out_ready,
  input logic [23:0] out_data
);
  import hwo_pkg::*;

  // A result that is not taken holds its word.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");

  // No input is taken while a result waits.
  a_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready)
    else $error("input ready while result pending");

  // A sample command blocks the input in the following cycle.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command == CMD_SAMPLE |=> !in_ready)
    else $error("ready right after sample command");

  // A table write or phase load produces no result.
  a_nores: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_command != CMD_SAMPLE |=> !out_valid)
    else $error("result after non-sample command");

endmodule

bind hermite_wavetable_oscillator hwo_checker u_hwo_checker (
  .clk(clk), .rst_n(rst_n), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .in_command(in_ch.command), .out_valid(out_ch.valid),
  .out_ready(out_ch.ready), .out_data(out_ch.sample_out)
);
